/* hdl/rational_arithmetic_unit_defines.svh */
// Assertion helpers for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/rau_pkg.sv */
`timescale 1ns / 1ps
package rau_pkg;
   localparam int OperandWidthDefault = 32;
   localparam int ResWidth = 64;
   localparam int OpWidth  = 3;

   localparam logic [OpWidth-1:0] OP_ADD   = 3'd0;
   localparam logic [OpWidth-1:0] OP_SUB   = 3'd1;
   localparam logic [OpWidth-1:0] OP_MUL   = 3'd2;
   localparam logic [OpWidth-1:0] OP_DIV   = 3'd3;
   localparam logic [OpWidth-1:0] OP_RED   = 3'd4;
   localparam logic [OpWidth-1:0] OP_RECIP = 3'd5;

   // command to the shared divider
   typedef struct packed {
      logic                start;
      logic [ResWidth-1:0] dividend;
      logic [ResWidth-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                done;
      logic                busy;
      logic [ResWidth-1:0] quot;
      logic [ResWidth-1:0] rem;
   } div_sts_type;
endpackage

/* hdl/rau_divider.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle over OPERAND_WIDTH bits.
module rau_divider
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = OperandWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_sts_type sts
);
   localparam int W  = OPERAND_WIDTH;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quot_ff, quot_in;
   logic [W-1:0]  rem_ff,  rem_in;
   logic [W-1:0]  dvs_ff,  dvs_in;
   logic [CW-1:0] cnt_ff,  cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic [W:0]    diff;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (cmd.start) begin
         quot_in = cmd.dividend[W-1:0];
         rem_in  = '0;
         dvs_in  = cmd.divisor[W-1:0];
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quot_in = {quot_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quot_in = {quot_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign sts.done = done_ff;
   assign sts.busy = busy_ff;
   assign sts.quot = ResWidth'(quot_ff);
   assign sts.rem  = ResWidth'(rem_ff);
endmodule

/* hdl/rational_arithmetic_unit.sv */
`timescale 1ns / 1ps
// Rational arithmetic unit: one item in flight at a time, shared multiplier and divider.
// Add/sub/mul: S_M0, S_M1, S_M2, S_ACC, S_OUT; divide adds S_M3 (one 32x32 product a cycle).
// Reduce: one divider pass per Euclid step (up to about 46 steps on 32-bit operands),
// two more passes to divide out the GCD; equal parts or zero denom go straight to S_OUT.
// Reciprocal and unused codes: straight to S_OUT. Next item accepted once the rsp beat is taken.
// Reset (synchronous, active high) idles the sequencer and drops rsp_valid.
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = OperandWidthDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OpWidth-1:0]         req_operation,
   input  logic signed [31:0]         req_lhs_numer,
   input  logic signed [31:0]         req_lhs_denom,
   input  logic signed [31:0]         req_rhs_numer,
   input  logic signed [31:0]         req_rhs_denom,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [ResWidth-1:0] rsp_res_numer,
   output logic signed [ResWidth-1:0] rsp_res_denom,
   output logic                       rsp_zero_denominator
);
`include "rational_arithmetic_unit_defines.svh"
   localparam int W = OPERAND_WIDTH;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_M0   = 4'd1;
   localparam logic [3:0] S_M1   = 4'd2;
   localparam logic [3:0] S_M2   = 4'd3;
   localparam logic [3:0] S_M3   = 4'd4;
   localparam logic [3:0] S_ACC  = 4'd5;
   localparam logic [3:0] S_GCD  = 4'd6;
   localparam logic [3:0] S_GW   = 4'd7;
   localparam logic [3:0] S_DN   = 4'd8;
   localparam logic [3:0] S_DNW  = 4'd9;
   localparam logic [3:0] S_DD   = 4'd10;
   localparam logic [3:0] S_DDW  = 4'd11;
   localparam logic [3:0] S_OUT  = 4'd12;

   logic [3:0]          state_ff, state_in;
   logic [OpWidth-1:0]  op_ff, op_in;
   logic [63:0]         a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [63:0]         p_ff, p_in, acc_ff, acc_in;
   logic [63:0]         rn_ff, rn_in, rd_ff, rd_in;
   logic [W-1:0]        gx_ff, gx_in, gy_ff, gy_in;
   logic signed [31:0]  mul_x, mul_y;
   logic signed [63:0]  mul_p;
   logic                accept;
   div_cmd_type         dcmd;
   div_sts_type         dsts;

   function automatic logic [63:0] sext(input logic [31:0] v);
      logic [63:0] r;
      r = {{(64-W){v[W-1]}}, v[W-1:0]};
      return r;
   endfunction

   function automatic logic [W-1:0] mag(input logic [63:0] v);
      logic [63:0] m;
      m = v[63] ? (64'd0 - v) : v;
      return m[W-1:0];
   endfunction

   rau_divider #(.OPERAND_WIDTH(W)) u_div (
      .clock(clock), .reset(reset), .cmd(dcmd), .sts(dsts)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid;
   // 32x32 signed product; operands are sign-extended so the low word carries them
   assign mul_p = mul_x * mul_y;

   always_comb begin
      mul_x = a_ff[31:0];
      mul_y = d_ff[31:0];
      unique case (state_ff)
         S_M1: begin mul_x = c_ff[31:0]; mul_y = b_ff[31:0]; end
         S_M2: begin mul_x = b_ff[31:0]; mul_y = d_ff[31:0]; end
         S_M3: begin mul_x = b_ff[31:0]; mul_y = c_ff[31:0]; end
         default: begin
            mul_x = a_ff[31:0];
            mul_y = (op_ff == OP_MUL) ? c_ff[31:0] : d_ff[31:0];
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      p_in = p_ff; acc_in = acc_ff; rn_in = rn_ff; rd_in = rd_ff;
      gx_in = gx_ff; gy_in = gy_ff;
      dcmd = '0;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            op_in = req_operation;
            a_in = sext(req_lhs_numer); b_in = sext(req_lhs_denom);
            c_in = sext(req_rhs_numer); d_in = sext(req_rhs_denom);
            unique case (req_operation) inside
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_in = S_M0;
               OP_RED:   state_in = S_GCD;
               default:  state_in = S_OUT;
            endcase
            gx_in = mag(sext(req_lhs_numer));
            gy_in = mag(sext(req_lhs_denom));
         end
         S_M0: begin p_in = mul_p; state_in = S_M1; end
         S_M1: begin
            acc_in = (op_ff == OP_SUB) ? (p_ff - mul_p) : (p_ff + mul_p);
            state_in = S_M2;
         end
         // mul and div keep the first product as numerator
         S_M2: begin
            acc_in = (op_ff == OP_MUL || op_ff == OP_DIV) ? p_ff : acc_ff;
            p_in = mul_p;
            state_in = (op_ff == OP_DIV) ? S_M3 : S_ACC;
         end
         S_M3: begin p_in = mul_p; state_in = S_ACC; end
         S_ACC: begin
            rn_in = acc_ff;
            rd_in = p_ff; state_in = S_OUT;
         end
         S_GCD: begin
            if (a_ff == b_ff || b_ff == 64'd0) state_in = S_OUT;
            else if (gy_ff == '0) state_in = S_DN;
            else begin
               dcmd.start = 1'b1;
               dcmd.dividend = 64'(gx_ff); dcmd.divisor = 64'(gy_ff);
               state_in = S_GW;
            end
         end
         S_GW: if (dsts.done) begin
            gx_in = gy_ff; gy_in = dsts.rem[W-1:0]; state_in = S_GCD;
         end
         S_DN: begin
            dcmd.start = 1'b1;
            dcmd.dividend = 64'(mag(a_ff)); dcmd.divisor = 64'(gx_ff);
            state_in = S_DNW;
         end
         S_DNW: if (dsts.done) begin
            rn_in = a_ff[63] ? (64'd0 - dsts.quot) : dsts.quot; state_in = S_DD;
         end
         S_DD: begin
            dcmd.start = 1'b1;
            dcmd.dividend = 64'(mag(b_ff)); dcmd.divisor = 64'(gx_ff);
            state_in = S_DDW;
         end
         S_DDW: if (dsts.done) begin
            rd_in = b_ff[63] ? (64'd0 - dsts.quot) : dsts.quot; state_in = S_OUT;
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   logic rsp_valid_ff, rsp_valid_in;
   logic [63:0] on_ff, on_in, od_ff, od_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      on_in = on_ff; od_in = od_ff;
      if (state_ff == S_OUT) begin
         rsp_valid_in = 1'b1;
         unique case (op_ff) inside
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin on_in = rn_ff; od_in = rd_ff; end
            OP_RED: begin
               if (a_ff == b_ff) begin on_in = 64'd1; od_in = 64'd1; end
               else if (b_ff == 64'd0) begin on_in = a_ff; od_in = b_ff; end
               else begin on_in = rn_ff; od_in = rd_ff; end
            end
            OP_RECIP: begin on_in = b_ff; od_in = a_ff; end
            default: begin on_in = '0; od_in = '0; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in; a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      p_ff <= p_in; acc_ff <= acc_in; rn_ff <= rn_in; rd_ff <= rd_in;
      gx_ff <= gx_in; gy_ff <= gy_in; on_ff <= on_in; od_ff <= od_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res_numer = on_ff;
   assign rsp_res_denom = od_ff;
   assign rsp_zero_denominator = (od_ff == 64'd0);

   `RAU_ASSERT_IMP(a_busy_stall, clock, reset, state_ff != S_IDLE, req_stall,
      "request accepted while busy")
   `RAU_ASSERT_NEXT(a_out_valid, clock, reset, state_ff == S_OUT, rsp_valid,
      "result not presented")
   `RAU_ASSERT_IMP(a_div_idle, clock, reset, dcmd.start, !dsts.busy,
      "divider restarted while busy")
endmodule
